>>> rtl/qpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared constants of the quaternion product / rotate unit: default widths,
// operation codes and the sign pattern of the Hamilton product.
// ----------------------------------------------------------------------------
package qpr_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    localparam logic [1:0] OP_PROD = 2'd0;
    localparam logic [1:0] OP_ROT  = 2'd1;
    localparam logic [1:0] OP_CONJ = 2'd2;

    // Result row r (w, x, y, z) sums a[k] * b[r ^ k]; bit k set means subtract.
    localparam logic [3:0][3:0] SIGN_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

endpackage

`default_nettype wire

>>> rtl/quaternion_product_rotate_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_product_rotate_unit
// Pipelined Q1.14 quaternion unit: Hamilton product, rotation of a vector by
// A as A*v*conj(A), and conjugate, with rounding and saturation flag.
//
//   channel  dir  tdata (low bit up)                         tuser
//   s_axis   in   a_w a_x a_y a_z b_w b_x b_y b_z            op
//   m_axis   out  r_w r_x r_y r_z, zero padded to bytes      saturated
//
// Six register stages: input, products, sums, products, sums, output.
// One beat per cycle sustained while m_tready is held high.
// Each stage has its own valid bit and advances when empty or when the
// stage after it advances, so bubbles close up under backpressure.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module quaternion_product_rotate_unit
    import qpr_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [8*COMP_WIDTH-1:0]                s_tdata,  // a_w a_x a_y a_z b_w b_x b_y b_z
    input  logic [1:0]                             s_tuser,  // op
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((4*COMP_WIDTH+7)/8)*8-1:0]      m_tdata,  // r_w r_x r_y r_z, pad
    output logic [0:0]                             m_tuser   // saturated
);

    localparam int W   = COMP_WIDTH;
    localparam int OTW = ((4 * COMP_WIDTH + 7) / 8) * 8;

    localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

    logic [5:0] valid_reg;
    logic [5:0] en;

    logic [3:0][W-1:0] a_in;
    logic [3:0][W-1:0] b_in;
    logic [3:0][W-1:0] conj_next;
    logic              csat_next;

    logic [1:0]        op0_reg, op1_reg, op2_reg, op3_reg, op4_reg;
    logic [3:0][W-1:0] a0_reg, b0_reg;
    logic [3:0][W-1:0] c0_reg, c1_reg, c2_reg, c3_reg, c4_reg;
    logic              cs0_reg, cs1_reg, cs2_reg, cs3_reg, cs4_reg;
    logic [3:0][W-1:0] t3_reg, t4_reg;
    logic [3:0]        f3_reg, f4_reg;

    logic [3:0][3:0][2*W-1:0] p1_reg, p3_reg;
    logic [3:0][W-1:0]        t2_reg, r4_reg;
    logic [3:0]               f2_reg, g4_reg;

    logic [4*W-1:0] out_data_next, out_data_reg;
    logic           out_sat_next, out_sat_reg;

    // stage enables
    assign en[5] = !valid_reg[5] || m_tready;
    for (genvar i = 0; i < 5; i++)
    begin : g_en
        assign en[i] = !valid_reg[i] || en[i+1];
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[5];
    assign m_tdata  = OTW'(out_data_reg);
    assign m_tuser  = out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < 6; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // input unpack and conjugate of A
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            a_in[i] = s_tdata[i*W +: W];
            b_in[i] = s_tdata[(4+i)*W +: W];
        end
        // vector w is zero for rotate
        if (s_tuser == OP_ROT)
        begin
            b_in[0] = '0;
        end
        conj_next[0] = a_in[0];
        csat_next    = 1'b0;
        for (int i = 1; i < 4; i++)
        begin
            if (a_in[i] == CMIN)
            begin
                conj_next[i] = CMAX;
                csat_next    = 1'b1;
            end
            else
            begin
                conj_next[i] = ~a_in[i] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            op0_reg   <= s_tuser;
            a0_reg    <= a_in;
            b0_reg    <= b_in;
            c0_reg    <= conj_next;
            cs0_reg   <= csat_next;
        end
        if (en[1])
        begin
            op1_reg <= op0_reg;
            c1_reg  <= c0_reg;
            cs1_reg <= cs0_reg;
        end
        if (en[2])
        begin
            op2_reg <= op1_reg;
            c2_reg  <= c1_reg;
            cs2_reg <= cs1_reg;
        end
        if (en[3])
        begin
            op3_reg <= op2_reg;
            c3_reg  <= c2_reg;
            cs3_reg <= cs2_reg;
            t3_reg  <= t2_reg;
            f3_reg  <= f2_reg;
        end
        if (en[4])
        begin
            op4_reg <= op3_reg;
            c4_reg  <= c3_reg;
            cs4_reg <= cs3_reg;
            t4_reg  <= t3_reg;
            f4_reg  <= f3_reg;
        end
        if (en[5])
        begin
            out_data_reg <= out_data_next;
            out_sat_reg  <= out_sat_next;
        end
    end

    // A*B, or A*v for rotate
    qpr_mul #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_mul_first (
        .clk      (clk),
        .en       (en[1]),
        .a        (a0_reg),
        .b        (b0_reg),
        .prod_reg (p1_reg)
    );

    qpr_round #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_round_first (
        .clk     (clk),
        .en      (en[2]),
        .prod    (p1_reg),
        .res_reg (t2_reg),
        .sat_reg (f2_reg)
    );

    // (A*v) * conj(A)
    qpr_mul #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_mul_second (
        .clk      (clk),
        .en       (en[3]),
        .a        (t2_reg),
        .b        (c2_reg),
        .prod_reg (p3_reg)
    );

    qpr_round #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_round_second (
        .clk     (clk),
        .en      (en[4]),
        .prod    (p3_reg),
        .res_reg (r4_reg),
        .sat_reg (g4_reg)
    );

    // result select; w row of the second product is not part of a rotate
    always_comb
    begin
        case (op4_reg)
            OP_PROD:
            begin
                out_data_next = t4_reg;
                out_sat_next  = |f4_reg;
            end
            OP_ROT:
            begin
                out_data_next = {r4_reg[3], r4_reg[2], r4_reg[1], {W{1'b0}}};
                out_sat_next  = (|f4_reg) || cs4_reg || (|g4_reg[3:1]);
            end
            OP_CONJ:
            begin
                out_data_next = c4_reg;
                out_sat_next  = cs4_reg;
            end
            default:
            begin
                out_data_next = '0;
                out_sat_next  = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/qpr_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpr_mul
// Multiplier stage: all sixteen component products of two quaternions,
// product [r][k] = a[k] * b[r ^ k], registered.
// ----------------------------------------------------------------------------
module qpr_mul
    import qpr_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [3:0][COMP_WIDTH-1:0]            a,
    input  logic [3:0][COMP_WIDTH-1:0]            b,
    output logic [3:0][3:0][2*COMP_WIDTH-1:0]     prod_reg
);

    logic signed [2*COMP_WIDTH-1:0] prod_next [4][4];

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar k = 0; k < 4; k++)
        begin : g_term
            assign prod_next[r][k] = $signed(a[k]) * $signed(b[r ^ k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    prod_reg[r][k] <= prod_next[r][k];
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/qpr_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpr_round
// Sum stage: signed sum of four products per row, round to nearest (ties
// upward), saturate to the component width and flag clipping, registered.
// ----------------------------------------------------------------------------
module qpr_round
    import qpr_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [3:0][3:0][2*COMP_WIDTH-1:0]     prod,
    output logic [3:0][COMP_WIDTH-1:0]            res_reg,
    output logic [3:0]                            sat_reg
);

    localparam int PW = 2 * COMP_WIDTH;
    localparam int SW = (PW + 3 > FRAC_BITS + 2) ? PW + 3 : FRAC_BITS + 2;

    localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic [COMP_WIDTH-1:0] CMAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic [COMP_WIDTH-1:0] CMIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    logic signed [SW-1:0]       acc [4];
    logic signed [SW-1:0]       shr [4];
    logic [3:0][COMP_WIDTH-1:0] res_next;
    logic [3:0]                 sat_next;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            acc[r] = HALF;
            for (int k = 0; k < 4; k++)
            begin
                if (SIGN_NEG[r][k])
                begin
                    acc[r] = acc[r] - SW'($signed(prod[r][k]));
                end
                else
                begin
                    acc[r] = acc[r] + SW'($signed(prod[r][k]));
                end
            end
            shr[r] = acc[r] >>> FRAC_BITS;
            if ((&shr[r][SW-1:COMP_WIDTH-1]) || !(|shr[r][SW-1:COMP_WIDTH-1]))
            begin
                res_next[r] = shr[r][COMP_WIDTH-1:0];
                sat_next[r] = 1'b0;
            end
            else if (shr[r][SW-1])
            begin
                res_next[r] = CMIN;
                sat_next[r] = 1'b1;
            end
            else
            begin
                res_next[r] = CMAX;
                sat_next[r] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

endmodule

`default_nettype wire
